// File: rtl/kmst_pkg.sv
// kmst_pkg: shared types and constants for the minimum spanning tree block
// no dependencies
`default_nettype none
package kmst_pkg;
  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned MaxEdges    = 4096;
  localparam int unsigned VtxW        = 10;
  localparam int unsigned CntW        = 11;
  localparam int unsigned EdgeAw      = 12;
  localparam int unsigned LoadW       = 13;
  localparam int unsigned WeightW     = 32;
  localparam int unsigned TotalW      = 42;

  typedef struct packed {
    logic [VtxW-1:0]    from;
    logic [VtxW-1:0]    to;
    logic [WeightW-1:0] w;
  } edge_t;

  typedef struct packed {
    logic [VtxW-1:0]    edge_from;
    logic [VtxW-1:0]    edge_to;
    logic [WeightW-1:0] edge_weight;
    logic               last_edge;
  } in_item_t;

  typedef struct packed {
    logic [TotalW-1:0] total_weight;
    logic [VtxW-1:0]   tree_edges;
    logic              spanning;
    logic              input_error;
  } out_item_t;
endpackage
`default_nettype wire

// File: rtl/kmst_if.sv
// kmst_if: valid/ready channel carrying one payload struct
// depends on kmst_pkg for the payload types
`default_nettype none
interface kmst_in_if;
  logic                valid;
  logic                ready;
  kmst_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface kmst_out_if;
  logic                valid;
  logic                ready;
  kmst_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/kruskal_minimum_spanning_tree_top.sv
// kruskal_minimum_spanning_tree_top: loads edges, heap sorts them in a RAM,
// runs union-find with path compression in a second RAM. uses kmst_pkg, kmst_if
//
// Usage: edges arrive on in_if, one request per cycle while loading. The
// request with last_edge set starts a run; in_if.ready stays low until the
// single result is taken from out_if. A result holds in the output register
// while the receiver stalls. The user must write vertex_count through
// cfg_we_i and cfg_wdata_i only while idle; the block does not enforce this.
// 0 acts as 1, values above 1024 as 1024. A run clears all 1024 entries of
// the parent table, heap sorts the loaded edges in the edge RAM, then walks
// the sorted edges, following parent hops to each root and relinking the
// entries on the way. The edge RAM and the parent RAM each have a single
// port, read one word a cycle with registered data. Reset clears the load
// and tree edge counters, the weight sum and the flags; the RAM contents
// are undefined until written, and the parent table is rebuilt at the
// start of every run. Edges beyond 4096 or naming a vertex at or above
// vertex_count are dropped and flagged in input_error.
`default_nettype none
module kruskal_minimum_spanning_tree_top (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [kmst_pkg::CntW-1:0] cfg_wdata_i,
  kmst_in_if.sink                      in_if,
  kmst_out_if.source                   out_if
);
  import kmst_pkg::*;

  typedef enum logic [16:0] {
    S_LOAD   = 17'h00001,
    S_CLEAR  = 17'h00002,
    S_HEAPI  = 17'h00004,
    S_SRDR   = 17'h00008,
    S_SRDL   = 17'h00010,
    S_SRDRR  = 17'h00020,
    S_SCMP   = 17'h00040,
    S_SWAPA  = 17'h00080,
    S_SWAPB  = 17'h00100,
    S_EXTR   = 17'h00200,
    S_WRD    = 17'h00400,
    S_WCHK   = 17'h00800,
    S_FIND   = 17'h01000,
    S_COMP   = 17'h02000,
    S_JOIN   = 17'h04000,
    S_OUT    = 17'h08000,
    S_CRD    = 17'h10000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]   vcnt_q;
  logic [CntW-1:0]   vc;
  logic [LoadW-1:0]  loaded_q, loaded_d;
  logic              drop_q, drop_d, err_q, err_d;

  // edge memory
  edge_t             emem [MaxEdges];
  logic              e_we;
  logic [EdgeAw-1:0] e_addr;
  edge_t             e_wdata, e_rdata;
  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_addr] <= e_wdata;
    e_rdata <= emem[e_addr];
  end

  // parent memory
  logic [VtxW-1:0]   pmem [MaxVertices];
  logic              p_we;
  logic [VtxW-1:0]   p_addr, p_wdata, p_rdata;
  always_ff @(posedge clk_i) begin
    if (p_we) pmem[p_addr] <= p_wdata;
    p_rdata <= pmem[p_addr];
  end

  // sort registers
  logic [LoadW-1:0]  heap_n_q, heap_n_d;   // heap size
  logic [LoadW-1:0]  init_q, init_d;       // build-phase countdown
  logic [LoadW-1:0]  root_q, root_d;
  logic [LoadW-1:0]  big_q, big_d;
  edge_t             re_q, re_d, be_q, be_d;
  logic              build_q, build_d;
  // walk registers
  logic [LoadW-1:0]  idx_q, idx_d;
  edge_t             cur_q, cur_d;
  logic [VtxW-1:0]   x_q, x_d, r_q, r_d, ra_q, ra_d;
  logic              second_q, second_d;
  logic [VtxW-1:0]   taken_q, taken_d;
  logic [TotalW-1:0] sum_q, sum_d;
  out_item_t         res_q, res_d;

  // child indexes carry one extra bit so the right child of the last slot
  // does not wrap back to the top of the heap
  logic [LoadW:0]    lch, rch;
  logic [LoadW:0]    heap_n_x;
  logic [VtxW-1:0]   vcm1;
  logic              in_fire;

  always_comb begin
    vc = vcnt_q;
    if (vc == '0) vc = CntW'(1);
    if (vc > CntW'(MaxVertices)) vc = CntW'(MaxVertices);
  end
  assign vcm1     = VtxW'(vc - CntW'(1));
  assign lch      = {root_q, 1'b1};
  assign rch      = lch + (LoadW+1)'(1);
  assign heap_n_x = {1'b0, heap_n_q};
  assign in_fire  = in_if.valid && in_if.ready;

  assign in_if.ready  = (state_q == S_LOAD);
  assign out_if.valid = (state_q == S_OUT);
  assign out_if.payload = res_q;

  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    drop_d   = drop_q;
    err_d    = err_q;
    heap_n_d = heap_n_q;
    init_d   = init_q;
    root_d   = root_q;
    big_d    = big_q;
    re_d     = re_q;
    be_d     = be_q;
    build_d  = build_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    x_d      = x_q;
    r_d      = r_q;
    ra_d     = ra_q;
    second_d = second_q;
    taken_d  = taken_q;
    sum_d    = sum_q;
    res_d    = res_q;
    e_we     = 1'b0;
    e_addr   = EdgeAw'(root_q);
    e_wdata  = re_q;
    p_we     = 1'b0;
    p_addr   = x_q;
    p_wdata  = x_q;
    unique case (state_q)
      S_LOAD: begin
        e_addr  = EdgeAw'(loaded_q);
        e_wdata = '{from: in_if.payload.edge_from, to: in_if.payload.edge_to,
                    w: in_if.payload.edge_weight};
        if (in_fire) begin
          if ({1'b0, in_if.payload.edge_from} >= vc || {1'b0, in_if.payload.edge_to} >= vc
              || loaded_q >= LoadW'(MaxEdges)) begin
            drop_d = 1'b1;
          end else begin
            e_we     = 1'b1;
            loaded_d = loaded_q + LoadW'(1);
          end
          if (in_if.payload.last_edge) begin
            err_d   = drop_d;
            heap_n_d = loaded_d;
            init_d  = LoadW'(loaded_d >> 1);
            build_d = 1'b1;
            x_d     = '0;
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        p_we    = 1'b1;
        p_addr  = x_q;
        p_wdata = x_q;
        x_d     = x_q + VtxW'(1);
        if (x_q == VtxW'(MaxVertices - 1)) state_d = S_HEAPI;
      end
      S_HEAPI: begin
        // next step: build phase counts down, then extraction, then walk
        if (build_q) begin
          if (init_q == '0) begin
            build_d = 1'b0;
          end else begin
            init_d  = init_q - LoadW'(1);
            root_d  = init_q - LoadW'(1);
            state_d = S_SRDR;
          end
        end else if (heap_n_q < LoadW'(2)) begin
          idx_d    = '0;
          taken_d  = '0;
          sum_d    = '0;
          state_d  = S_WRD;
        end else begin
          root_d  = '0;
          e_addr  = '0;
          state_d = S_EXTR;
        end
      end
      S_EXTR: begin
        // swap top with last: read last (addr 0 read issued), then swap
        e_addr  = EdgeAw'(heap_n_q - LoadW'(1));
        re_d    = e_rdata;  // top entry
        root_d  = '0;
        state_d = S_SWAPA;
        big_d   = heap_n_q - LoadW'(1);
        heap_n_d = heap_n_q - LoadW'(1);
        be_d    = e_rdata;
        build_d = 1'b0;
        second_d = 1'b1; // marks extraction swap
      end
      S_SRDR: begin
        e_addr  = EdgeAw'(root_q);
        state_d = S_SRDL;
      end
      S_SRDL: begin
        re_d    = e_rdata;
        be_d    = e_rdata;
        big_d   = root_q;
        e_addr  = EdgeAw'(lch);
        state_d = S_SRDRR;
      end
      S_SRDRR: begin
        if (lch < heap_n_x && e_rdata.w > be_q.w) begin
          be_d  = e_rdata;
          big_d = LoadW'(lch);
        end
        e_addr  = EdgeAw'(rch);
        state_d = S_SCMP;
      end
      S_SCMP: begin
        if (rch < heap_n_x && e_rdata.w > be_q.w) begin
          be_d  = e_rdata;
          big_d = LoadW'(rch);
        end
        if ((rch < heap_n_x && e_rdata.w > be_q.w) || big_q != root_q) begin
          second_d = 1'b0;
          state_d  = S_SWAPA;
        end else begin
          state_d = S_HEAPI;
        end
      end
      S_SWAPA: begin
        e_we    = 1'b1;
        e_addr  = EdgeAw'(root_q);
        e_wdata = second_q ? e_rdata : be_q;
        state_d = S_SWAPB;
      end
      S_SWAPB: begin
        e_we    = 1'b1;
        e_addr  = EdgeAw'(big_q);
        e_wdata = re_q;
        if (second_q) begin
          root_d  = '0;
          state_d = S_SRDR;
        end else begin
          root_d  = big_q;
          state_d = S_SRDR;
        end
      end
      S_WRD: begin
        e_addr = EdgeAw'(idx_q);
        if (idx_q >= loaded_q || taken_q == vcm1) begin
          res_d = '{total_weight: sum_q, tree_edges: taken_q,
                    spanning: (taken_q == vcm1), input_error: err_q};
          state_d = S_OUT;
        end else begin
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        cur_d = e_rdata;
        idx_d = idx_q + LoadW'(1);
        if ({1'b0, e_rdata.from} >= vc || {1'b0, e_rdata.to} >= vc) begin
          err_d   = 1'b1;
          state_d = S_WRD;
        end else begin
          x_d      = e_rdata.from;
          r_d      = e_rdata.from;
          p_addr   = e_rdata.from;
          second_d = 1'b0;
          state_d  = S_FIND;
        end
      end
      S_FIND: begin
        // p_rdata is parent of r_q
        if (p_rdata == r_q) begin
          p_addr  = x_q;
          state_d = S_COMP;
        end else begin
          r_d    = p_rdata;
          p_addr = p_rdata;
        end
      end
      S_COMP: begin
        // p_rdata is parent of x_q; relink toward root
        if (p_rdata == r_q || x_q == r_q) begin
          if (!second_q) begin
            ra_d     = r_q;
            second_d = 1'b1;
            x_d      = cur_q.to;
            r_d      = cur_q.to;
            p_addr   = cur_q.to;
            state_d  = S_FIND;
          end else begin
            state_d = S_JOIN;
          end
        end else begin
          p_we    = 1'b1;
          p_addr  = x_q;
          p_wdata = r_q;
          x_d     = p_rdata;
          state_d = S_CRD;
        end
      end
      S_CRD: begin
        // port was busy with the relink write; fetch parent of the next x
        p_addr  = x_q;
        state_d = S_COMP;
      end
      S_JOIN: begin
        if (ra_q != r_q) begin
          p_we    = 1'b1;
          p_addr  = ra_q;
          p_wdata = r_q;
          sum_d   = sum_q + TotalW'(cur_q.w);
          taken_d = taken_q + VtxW'(1);
        end
        state_d = S_WRD;
      end
      S_OUT: begin
        if (out_if.ready) begin
          loaded_d = '0;
          drop_d   = 1'b0;
          state_d  = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_LOAD;
      vcnt_q   <= CntW'(MaxVertices);
      loaded_q <= '0;
      drop_q   <= 1'b0;
      err_q    <= 1'b0;
      build_q  <= 1'b0;
      second_q <= 1'b0;
      taken_q  <= '0;
      sum_q    <= '0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
      loaded_q <= loaded_d;
      drop_q   <= drop_d;
      err_q    <= err_d;
      build_q  <= build_d;
      second_q <= second_d;
      taken_q  <= taken_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    heap_n_q <= heap_n_d;
    init_q   <= init_d;
    root_q   <= root_d;
    big_q    <= big_d;
    re_q     <= re_d;
    be_q     <= be_d;
    idx_q    <= idx_d;
    cur_q    <= cur_d;
    x_q      <= x_d;
    r_q      <= r_d;
    ra_q     <= ra_d;
    res_q    <= res_d;
  end
endmodule
`default_nettype wire
